>>> sv/kto_pkg.sv
package kto_pkg;

    // Defaults for the top-level parameters.
    localparam int BUFFER_SAMPLES_DEFAULT   = 48000;
    localparam int PHASE_BITS_DEFAULT       = 32;
    localparam int SINE_TABLE_DEPTH_DEFAULT = 1024;

    // Fixed-point constants.
    localparam int          STEP_W      = 31;
    localparam int          KEY_W       = 7;
    localparam int          KEY_RESET   = 69;
    localparam int          FULL_SCALE  = 32767;
    localparam int          ENV_MIN_RAMP = 48;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    // Shared divider geometry.
    localparam int DIV_W     = 32;
    localparam int DIV_LOW_W = 16;
    localparam int DIV_Q_W   = 16;
    localparam int DIV_CNT_W = 5;

    // The square period is below 2^13 for every key.
    localparam int                   PERIOD_W        = 13;
    localparam logic [DIV_CNT_W-1:0] PERIOD_ITERS    = DIV_CNT_W'(PERIOD_W);
    localparam logic [DIV_CNT_W-1:0] ENV_ITERS       = DIV_CNT_W'(DIV_LOW_W);
    localparam logic [DIV_W-1:0]     PERIOD_REM_INIT = DIV_W'((64'd1 << 32) >> PERIOD_W);

    // Phase step of the top octave, rounded f/48000*2^32.
    localparam logic [STEP_W-1:0] TOP_OCTAVE_STEP [12] = '{
        31'd749115498,  31'd793660223,  31'd840853716,  31'd890853481,
        31'd943826385,  31'd999949222,  31'd1059409297, 31'd1122405052,
        31'd1189146729, 31'd1259857073, 31'd1334772074, 31'd1414141751
    };

    // Request to the shared divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     rem_init;
        logic [DIV_LOW_W-1:0] low_bits;
        logic [DIV_W-1:0]     divisor;
        logic [DIV_CNT_W-1:0] iters;
    } kto_div_req_t;

    // Status and result of the shared divider.
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_Q_W-1:0] quotient;
    } kto_div_rsp_t;

    // Unshifted 32-bit phase step of a key: the top-octave entry moved down by octaves.
    function automatic logic [STEP_W-1:0] key_step(input logic [KEY_W-1:0] key);
        logic [3:0]       octave;
        logic [KEY_W-1:0] rest;
        logic [3:0]       note;
        octave = 4'd0;
        for (int o = 1; o <= 10; o++)
        begin
            if (key >= KEY_W'(12 * o))
            begin
                octave = 4'(o);
            end
        end
        rest = key - KEY_W'(octave) * KEY_W'(12);
        note = rest[3:0];
        return TOP_OCTAVE_STEP[note] >> (4'd10 - octave);
    endfunction

    // Quarter-wave sine magnitude, Q30 Taylor series up to x^9, rounded and clamped.
    // Entry q sits at the angle q/2^(ld-2) of a quarter turn.
    function automatic logic [14:0] sine_mag(input int unsigned q, input int unsigned ld);
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] mag;
        frac = 64'(q) << (32 - ld);
        x    = (frac * Q30_HALF_PI) >> 30;
        x2   = (x * x) >> 30;
        t    = Q30_ONE - x2 / 64'd72;
        t    = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t    = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t    = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s    = (x * t) >> 30;
        mag  = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
        if (mag > 64'(FULL_SCALE))
        begin
            mag = 64'(FULL_SCALE);
        end
        return mag[14:0];
    endfunction

    // State reset: key 69, its step and its square period.
    localparam logic [STEP_W-1:0]   STEP_RESET   = key_step(KEY_W'(KEY_RESET));
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'((64'd1 << 32) / STEP_RESET);

endpackage

>>> sv/kto_divider.sv
module kto_divider
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  kto_pkg::kto_div_req_t req,
    output kto_pkg::kto_div_rsp_t rsp
);
    import kto_pkg::*;

    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     divisor_reg;
    logic [DIV_LOW_W-1:0] low_reg;
    logic [DIV_Q_W-1:0]   quo_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           fits;

    // One restoring step: bring down the next dividend bit and try the subtract.
    assign trial = {rem_reg, low_reg[DIV_LOW_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = (trial >= {1'b0, divisor_reg});

    // Control: a start loads the operands, then one quotient bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= req.iters;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - DIV_CNT_W'(1);
                if (count_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the partial remainder stays below the divisor.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= req.rem_init;
            low_reg     <= req.low_bits;
            divisor_reg <= req.divisor;
            quo_reg     <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            low_reg <= {low_reg[DIV_LOW_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_Q_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> sv/key_tone_oscillator_with_envelope_top.sv
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: key; tuser: note_on
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: sample; tlast: buffer_end
// cfg       in         cfg_we (no wait)              cfg_index, cfg_wdata
//
// One tick at a time. A tick runs the sine table read, the amplitude multiply and the scaling;
// unless the ramp length is below ENV_MIN_RAMP it then runs the envelope multiply and the
// shared divider, or saturates at once when the quotient would overflow.
// A tick with note_on first runs the 13-step square-period division.
// Input is ready again in the cycle after the sample is loaded into the output word.
// A stalled output word holds the sequencer in its last step. Reset is immediate.
module key_tone_oscillator_with_envelope_top
#(
    parameter int BUFFER_SAMPLES   = kto_pkg::BUFFER_SAMPLES_DEFAULT,
    parameter int PHASE_BITS       = kto_pkg::PHASE_BITS_DEFAULT,
    parameter int SINE_TABLE_DEPTH = kto_pkg::SINE_TABLE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input ticks.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] key, [7] zero
    input  logic        s_axis_tuser,   // [0] note_on
    // Output samples.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample (signed)
    output logic        m_axis_tlast,   // buffer_end
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import kto_pkg::*;

    // Sine table depth is a power of two; only a quarter wave plus its end point is stored.
    localparam int SINE_LOG2   = $clog2(SINE_TABLE_DEPTH);
    localparam int QUART_DEPTH = SINE_TABLE_DEPTH / 4 + 1;
    localparam int QADDR_W     = SINE_LOG2 - 1;
    localparam int PHASE_SHIFT = 32 - PHASE_BITS;

    localparam logic [15:0] BUF_SAMPLES = 16'(BUFFER_SAMPLES);
    localparam logic [15:0] BUF_LAST    = 16'(BUFFER_SAMPLES - 1);

    // Register indexes.
    localparam logic [1:0] REG_WAVE_SELECT   = 2'd0;
    localparam logic [1:0] REG_AMPLITUDE     = 2'd1;
    localparam logic [1:0] REG_RAMP_LENGTH   = 2'd2;
    localparam logic [1:0] REG_ENVELOPE_MODE = 2'd3;

    // Waveform codes.
    localparam logic [1:0] WAVE_SINE   = 2'd0;
    localparam logic [1:0] WAVE_SQUARE = 2'd1;
    localparam logic [1:0] WAVE_HALF   = 2'd2;
    localparam logic [1:0] WAVE_FULL   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PERIOD_GO,
        S_PERIOD_WAIT,
        S_ROM,
        S_MUL_AMP,
        S_SCALE,
        S_MUL_ENV,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FINISH
    } state_t;

    // Configuration registers.
    logic [1:0]  wave_reg;
    logic [14:0] amplitude_reg;
    logic [15:0] ramp_reg;
    logic        mode_reg;

    // Tone state.
    state_t                state_reg;
    logic [15:0]           index_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [15:0]           square_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [PERIOD_W-1:0]   period_reg;

    // Per-tick datapath.
    logic [14:0] rom_reg;
    logic        sine_neg_reg;
    logic [29:0] prod_reg;
    logic [14:0] tone_mag_reg;
    logic        tone_neg_reg;
    logic [15:0] gain_reg;
    logic [30:0] prod2_reg;
    logic [15:0] result_reg;

    // Output word.
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        out_last_reg;

    kto_div_req_t div_req;
    kto_div_rsp_t div_rsp;

    // Quarter-wave sine table, filled at elaboration.
    logic [14:0] qtab [QUART_DEPTH];
    for (genvar g = 0; g < QUART_DEPTH; g++)
    begin : g_qtab
        localparam logic [14:0] ENTRY = sine_mag(g, SINE_LOG2);
        assign qtab[g] = ENTRY;
    end

    // Saturate a signed quotient given as sign and magnitude.
    function automatic logic [15:0] saturate(input logic neg, input logic over,
                                             input logic [15:0] q);
        logic [15:0] r;
        if (neg)
        begin
            r = (over || q > 16'd32768) ? 16'h8000 : 16'(16'd0 - q);
        end
        else
        begin
            r = (over || q > 16'd32767) ? 16'h7FFF : q;
        end
        return r;
    endfunction

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg      <= WAVE_SINE;
            amplitude_reg <= 15'(FULL_SCALE);
            ramp_reg      <= '0;
            mode_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WAVE_SELECT:   wave_reg      <= cfg_wdata[1:0];
                REG_AMPLITUDE:     amplitude_reg <= cfg_wdata[14:0];
                REG_RAMP_LENGTH:   ramp_reg      <= cfg_wdata;
                REG_ENVELOPE_MODE: mode_reg      <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // Sine table address: fold the phase into the first quadrant.
    logic [SINE_LOG2-1:0] sine_idx;
    logic [QADDR_W-1:0]   qaddr;
    assign sine_idx = phase_reg[PHASE_BITS-1 -: SINE_LOG2];
    assign qaddr    = sine_idx[SINE_LOG2-2]
                    ? QADDR_W'(QUART_DEPTH - 1) - {1'b0, sine_idx[SINE_LOG2-3:0]}
                    : {1'b0, sine_idx[SINE_LOG2-3:0]};

    // Amplitude scaling: divide by 32767 as a shift plus one correction step.
    logic [14:0] scale_q0;
    logic [16:0] scale_rem;
    logic [14:0] sine_val;
    assign scale_q0  = prod_reg[29:15];
    assign scale_rem = 17'(prod_reg[14:0]) + 17'(scale_q0);
    assign sine_val  = scale_q0 + 15'(scale_rem >= 17'(FULL_SCALE));

    // Waveform selection, as sign and magnitude.
    logic [14:0] tone_mag;
    logic        tone_neg;
    always_comb
    begin
        case (wave_reg)
            WAVE_SQUARE:
            begin
                tone_mag = amplitude_reg;
                tone_neg = (square_reg > 16'(period_reg[PERIOD_W-1:1]));
            end
            WAVE_HALF:
            begin
                tone_mag = sine_neg_reg ? 15'd0 : sine_val;
                tone_neg = 1'b0;
            end
            WAVE_FULL:
            begin
                tone_mag = sine_val;
                tone_neg = 1'b0;
            end
            default:
            begin
                tone_mag = sine_val;
                tone_neg = sine_neg_reg;
            end
        endcase
    end

    // Envelope gain and the short-ramp bypass.
    logic [15:0] env_gain;
    logic        env_bypass;
    logic        env_over;
    assign env_bypass = (ramp_reg < 16'(ENV_MIN_RAMP));
    assign env_gain   = mode_reg ? BUF_SAMPLES
                      : ((index_reg < ramp_reg) ? index_reg : BUF_SAMPLES - index_reg);
    assign env_over   = ({1'b0, prod2_reg} >= {ramp_reg, 16'd0});

    // Divider requests: the square period on a new note, the envelope quotient when shaping.
    always_comb
    begin
        div_req.start = (state_reg == S_PERIOD_GO) || ((state_reg == S_DIV_GO) && !env_over);
        if (state_reg == S_PERIOD_GO)
        begin
            div_req.rem_init = PERIOD_REM_INIT;
            div_req.low_bits = '0;
            div_req.divisor  = DIV_W'(step_reg);
            div_req.iters    = PERIOD_ITERS;
        end
        else
        begin
            div_req.rem_init = DIV_W'(prod2_reg[30:16]);
            div_req.low_bits = prod2_reg[15:0];
            div_req.divisor  = DIV_W'(ramp_reg);
            div_req.iters    = ENV_ITERS;
        end
    end

    kto_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // End-of-tick state advance.
    logic        last;
    logic [16:0] square_inc;
    assign last       = (index_reg >= BUF_LAST);
    assign square_inc = 17'(square_reg) + 17'd1;

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            index_reg     <= '0;
            phase_reg     <= '0;
            square_reg    <= '0;
            step_reg      <= STEP_RESET;
            period_reg    <= PERIOD_RESET;
            rom_reg       <= '0;
            sine_neg_reg  <= 1'b0;
            prod_reg      <= '0;
            tone_mag_reg  <= '0;
            tone_neg_reg  <= 1'b0;
            gain_reg      <= '0;
            prod2_reg     <= '0;
            result_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // A taken word is dropped unless the last step reloads it in the same cycle.
            if (out_valid_reg && m_axis_tready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (s_axis_tuser)
                        begin
                            step_reg   <= key_step(s_axis_tdata[KEY_W-1:0]);
                            index_reg  <= '0;
                            phase_reg  <= '0;
                            square_reg <= '0;
                            state_reg  <= S_PERIOD_GO;
                        end
                        else
                        begin
                            state_reg <= S_ROM;
                        end
                    end
                end
                S_PERIOD_GO:
                begin
                    state_reg <= S_PERIOD_WAIT;
                end
                S_PERIOD_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        period_reg <= div_rsp.quotient[PERIOD_W-1:0];
                        state_reg  <= S_ROM;
                    end
                end
                S_ROM:
                begin
                    rom_reg      <= qtab[qaddr];
                    sine_neg_reg <= sine_idx[SINE_LOG2-1];
                    state_reg    <= S_MUL_AMP;
                end
                S_MUL_AMP:
                begin
                    prod_reg  <= 30'(amplitude_reg) * 30'(rom_reg);
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    tone_mag_reg <= tone_mag;
                    tone_neg_reg <= tone_neg;
                    gain_reg     <= env_gain;
                    if (env_bypass)
                    begin
                        result_reg <= saturate(tone_neg, 1'b0, 16'(tone_mag));
                        state_reg  <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_MUL_ENV;
                    end
                end
                S_MUL_ENV:
                begin
                    prod2_reg <= 31'(tone_mag_reg) * 31'(gain_reg);
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    if (env_over)
                    begin
                        result_reg <= saturate(tone_neg_reg, 1'b1, 16'd0);
                        state_reg  <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        result_reg <= saturate(tone_neg_reg, 1'b0, div_rsp.quotient);
                        state_reg  <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= result_reg;
                        out_last_reg  <= last;
                        if (last)
                        begin
                            index_reg  <= '0;
                            phase_reg  <= '0;
                            square_reg <= '0;
                        end
                        else
                        begin
                            index_reg  <= index_reg + 16'd1;
                            phase_reg  <= phase_reg + PHASE_BITS'(step_reg >> PHASE_SHIFT);
                            square_reg <= (square_inc >= 17'(period_reg))
                                        ? 16'd0 : square_inc[15:0];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // The divider is only started when it is free.
    assert property (@(posedge clk) disable iff (!rst_n) div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // No tick is taken while a division is in flight.
    assert property (@(posedge clk) disable iff (!rst_n) div_rsp.busy |-> !s_axis_tready)
        else $error("input ready during a division");

    // The square period stays within the range that the key table gives.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (period_reg >= 13'd3) && (period_reg <= 13'd5871))
        else $error("square period out of range");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int N_SAMPLES  = kto_pkg::BUFFER_SAMPLES_DEFAULT;
    localparam int PHASE_W    = kto_pkg::PHASE_BITS_DEFAULT;
    localparam int SINE_DEPTH = kto_pkg::SINE_TABLE_DEPTH_DEFAULT;
    localparam int MIN_RAMP   = kto_pkg::ENV_MIN_RAMP;
    localparam int FULL       = kto_pkg::FULL_SCALE;

    typedef enum logic [1:0] {
        WAVE_SINE,
        WAVE_SQUARE,
        WAVE_HALF_RECT,
        WAVE_FULL_RECT
    } wave_t;

    typedef enum logic [1:0] {
        REG_WAVE,
        REG_AMPLITUDE,
        REG_RAMP,
        REG_ENV_MODE
    } reg_t;

    typedef struct {
        logic [15:0] sample;
        logic        buffer_end;
    } audio_word_t;

    // Tracks the oscillator state and holds the samples still owed by the block.
    class osc_model;
        int          sine_tab [SINE_DEPTH];
        wave_t       wave;
        int          amp;
        int          ramp;
        logic        env_mode;
        int          idx;
        longint      phase;
        int          sq_count;
        int          key;
        audio_word_t owed [$];
        int          errors;

        function new();
            logic [63:0] turn;
            logic [63:0] quad;
            logic [63:0] frac;
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] t;
            logic [63:0] s;
            logic [63:0] mag;
            // Sine table from a Q30 Taylor series over the first quadrant.
            for (int i = 0; i < SINE_DEPTH; i++)
            begin
                turn = (64'(i) << 32) / 64'(SINE_DEPTH);
                quad = (turn >> 30) & 64'd3;
                frac = turn & (kto_pkg::Q30_ONE - 64'd1);
                if (quad[0])
                begin
                    frac = kto_pkg::Q30_ONE - frac;
                end
                x   = (frac * kto_pkg::Q30_HALF_PI) >> 30;
                x2  = (x * x) >> 30;
                t   = kto_pkg::Q30_ONE - x2 / 64'd72;
                t   = kto_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd42;
                t   = kto_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd20;
                t   = kto_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd6;
                s   = (x * t) >> 30;
                mag = (s * 64'(FULL) + (64'd1 << 29)) >> 30;
                if (mag > 64'(FULL))
                begin
                    mag = 64'(FULL);
                end
                sine_tab[i] = (quad >= 64'd2) ? -int'(mag) : int'(mag);
            end
            wave     = WAVE_SINE;
            amp      = FULL;
            ramp     = 0;
            env_mode = 1'b0;
            idx      = 0;
            phase    = 0;
            sq_count = 0;
            key      = kto_pkg::KEY_RESET;
            errors   = 0;
        endfunction

        function void write_reg(reg_t r, logic [15:0] v);
            case (r)
                REG_WAVE:      wave = wave_t'(v[1:0]);
                REG_AMPLITUDE: amp = int'(v[14:0]);
                REG_RAMP:      ramp = int'(v);
                REG_ENV_MODE:  env_mode = v[0];
                default:       ;
            endcase
        endfunction

        function longint phase_step(int k);
            return longint'(kto_pkg::TOP_OCTAVE_STEP[k % 12]) >> (10 - k / 12);
        endfunction

        function longint square_period(int k);
            return (longint'(1) << 32) / phase_step(k);
        endfunction

        function int tone_value();
            logic [63:0] tab_idx;
            int          sv;
            if (wave == WAVE_SQUARE)
            begin
                return (longint'(sq_count) > square_period(key) / 2) ? -amp : amp;
            end
            tab_idx = (64'(phase) * 64'(SINE_DEPTH)) >> PHASE_W;
            sv = int'((longint'(amp) * longint'(sine_tab[tab_idx])) / FULL);
            if (wave == WAVE_HALF_RECT)
            begin
                return (sv >= 0) ? sv : 0;
            end
            if (wave == WAVE_FULL_RECT)
            begin
                return (sv >= 0) ? sv : -sv;
            end
            return sv;
        endfunction

        // Linear rise and fall over the buffer, or constant gain of buffer over ramp; none below MIN_RAMP.
        function longint envelope(int v);
            if (ramp < MIN_RAMP)
            begin
                return v;
            end
            if (env_mode)
            begin
                return (longint'(v) * N_SAMPLES) / ramp;
            end
            if (idx < ramp)
            begin
                return (longint'(v) * idx) / ramp;
            end
            return (longint'(v) * (N_SAMPLES - idx)) / ramp;
        endfunction

        // One accepted tick: work out its sample, then advance the oscillator.
        function void note_tick(logic note_on, logic [6:0] key_in);
            audio_word_t w;
            longint      v;
            logic        last;
            if (note_on)
            begin
                key      = int'(key_in);
                idx      = 0;
                phase    = 0;
                sq_count = 0;
            end
            v = envelope(tone_value());
            if (v > 32767)
            begin
                v = 32767;
            end
            if (v < -32768)
            begin
                v = -32768;
            end
            last         = (idx >= N_SAMPLES - 1);
            w.sample     = 16'(v);
            w.buffer_end = last;
            owed.push_back(w);
            if (last)
            begin
                idx      = 0;
                phase    = 0;
                sq_count = 0;
            end
            else
            begin
                idx   = (idx + 1) & 16'hFFFF;
                phase = (phase + (phase_step(key) >> (32 - PHASE_W))) & 64'hFFFF_FFFF;
                if (longint'(sq_count + 1) >= square_period(key))
                begin
                    sq_count = 0;
                end
                else
                begin
                    sq_count = (sq_count + 1) & 16'hFFFF;
                end
            end
        endfunction

        function void check_sample(logic [15:0] data, logic last);
            audio_word_t w;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected sample, expected none, actual %0d",
                         $time, $signed(data));
                errors++;
                return;
            end
            w = owed.pop_front();
            if (data !== w.sample)
            begin
                $display("%0t: sample mismatch, expected %0d, actual %0d",
                         $time, $signed(w.sample), $signed(data));
                errors++;
            end
            if (last !== w.buffer_end)
            begin
                $display("%0t: buffer_end mismatch, expected %0b, actual %0b",
                         $time, w.buffer_end, last);
                errors++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_wdata = 16'd0;

    osc_model osc;
    bit       idle_on;

    key_tone_oscillator_with_envelope_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Send one tick word, with an optional gap before it.
    task automatic send_tick(input logic note_on, input logic [6:0] key);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, key};
        s_axis_tuser  <= note_on;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        osc.note_tick(note_on, key);
    endtask

    task automatic write_reg(input reg_t r, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        @(posedge clk);
        osc.write_reg(r, v);
    endtask

    task automatic set_config(input logic [15:0] wave, input logic [15:0] amp,
                              input logic [15:0] ramp, input logic [15:0] mode);
        write_reg(REG_WAVE, wave);
        write_reg(REG_AMPLITUDE, amp);
        write_reg(REG_RAMP, ramp);
        write_reg(REG_ENV_MODE, mode);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and wait until every owed sample has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (osc.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic random_config();
        logic [15:0] wave;
        logic [15:0] amp;
        logic [15:0] ramp;
        logic [15:0] mode;
        int          pick;
        wave = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        mode = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        case (pick)
            0:       amp = 16'd0;
            1:       amp = 16'd32767;
            2, 3:    amp = 16'($urandom);
            default: amp = 16'($urandom_range(0, 32767));
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1:    ramp = 16'($urandom_range(0, MIN_RAMP - 1));
            6, 7:    ramp = 16'($urandom_range(1501, N_SAMPLES));
            8:       ramp = 16'hFFFF;
            9:       ramp = 16'($urandom_range(N_SAMPLES, 65535));
            default: ramp = 16'($urandom_range(MIN_RAMP, 1500));
        endcase
        set_config(wave, amp, ramp, mode);
    endtask

    // Output side: random stall bursts while idling is on, checking each word taken.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                osc.check_sample(m_axis_tdata, m_axis_tlast);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus.
    initial
    begin
        osc = new();
        idle_on = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: the reset key, then the highest and lowest keys.
        send_tick(1'b0, 7'd69);
        send_tick(1'b1, 7'd127);
        send_tick(1'b0, 7'd5);
        send_tick(1'b0, 7'd0);
        send_tick(1'b1, 7'd0);
        send_tick(1'b0, 7'd0);
        drain();

        // Square at the shortest period, wide amplitude write, ramp just under the limit.
        set_config(16'(WAVE_SQUARE), 16'hFFFF, 16'd47, 16'd0);
        send_tick(1'b1, 7'd127);
        repeat (4) send_tick(1'b0, 7'd127);
        drain();

        // Half-wave with constant gain far above one: saturation.
        set_config(16'(WAVE_HALF_RECT), 16'd1000, 16'd48, 16'd1);
        send_tick(1'b1, 7'd69);
        repeat (3) send_tick(1'b0, 7'd0);
        drain();

        // Full-wave with wide writes of the select, ramp and mode registers.
        set_config(16'hFFFF, 16'd32767, 16'hFFFF, 16'hFFFE);
        send_tick(1'b1, 7'd50);
        repeat (2) send_tick(1'b0, 7'd127);
        drain();

        // Zero amplitude with the shortest ramp that still shapes.
        set_config(16'(WAVE_SINE), 16'd0, 16'd48, 16'd0);
        send_tick(1'b1, 7'd60);
        repeat (2) send_tick(1'b0, 7'd60);
        drain();

        // Random phases: mostly plain ticks with random key bits, sparse note starts.
        for (int p = 0; p < 9; p++)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            random_config();
            for (int n = 0; n < 140; n++)
            begin
                send_tick(($urandom_range(0, 29) == 0) || (n == 0 && p[0]),
                          7'($urandom));
            end
            drain();
        end

        // Closing run without idling: back-to-back blocks of sine, square, full-wave and a random waveform.
        idle_on = 1'b0;
        set_config(16'(WAVE_SINE), 16'd32767, 16'd0, 16'd0);
        send_tick(1'b1, 7'($urandom_range(40, 127)));
        repeat (29) send_tick(1'b0, 7'($urandom));
        drain();
        set_config(16'(WAVE_SQUARE), 16'd20000, 16'd30, 16'd1);
        repeat (30) send_tick(1'b0, 7'($urandom));
        drain();
        set_config(16'(WAVE_FULL_RECT), 16'd32767, 16'd0, 16'd0);
        repeat (30) send_tick(1'b0, 7'($urandom));
        drain();
        set_config(16'($urandom_range(0, 3)), 16'd30000, 16'd24000, 16'd0);
        repeat (30) send_tick(1'b0, 7'($urandom));
        drain();

        repeat (40) @(posedge clk);
        if (osc.pending() != 0)
        begin
            $display("%0t: %0d samples never arrived", $time, osc.pending());
        end
        if (osc.errors == 0 && osc.pending() == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial
    begin
        #(100_000_000);
        $display("tb_top failed");
        $finish;
    end

endmodule
